@@ rtl/ccl_pkg.sv @@
// ----------------------------------------------------------------------------
// ccl_pkg
// Shared constants, types and arithmetic helpers for the capstan cable
// length pipeline.
// ----------------------------------------------------------------------------
package ccl_pkg;

  localparam int CORDIC_ITERATIONS = 24;
  localparam int ATAN_LEN          = 40;
  localparam int SQRT_BITS         = 41;
  localparam int NORM_TOP          = 58;

  localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;

  localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1,
    32'd1,         32'd0,         32'd0,         32'd0,        32'd0,
    32'd0,         32'd0,         32'd0,         32'd0,        32'd0
  };

  typedef enum logic [1:0] {
    REG_ANCHOR_X     = 2'd0,
    REG_ANCHOR_Y     = 2'd1,
    REG_RADIUS       = 2'd2,
    REG_ANGLE_ORIGIN = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [63:0] x;
    logic [63:0] y;
    logic [31:0] z;
  } vec_t;

  typedef struct packed {
    logic [66:0] rem;
    logic [40:0] res;
    vec_t        dv;
    logic        dzero;
    logic        interior;
  } sq_t;

  typedef struct packed {
    vec_t        v;
    logic [31:0] diff;
    logic [32:0] ucl;
    logic        interior;
    logic        tzero;
  } tg_t;

  function automatic vec_t cordic_step(vec_t v, int i);
    vec_t        o;
    logic [63:0] sx;
    logic [63:0] sy;
    sx = $signed(v.x) >>> i;
    sy = $signed(v.y) >>> i;
    if (v.y[63]) begin
      o.x = v.x - sy;
      o.y = v.y + sx;
      o.z = v.z - ATAN_TAB[i];
    end else begin
      o.x = v.x + sy;
      o.y = v.y - sx;
      o.z = v.z + ATAN_TAB[i];
    end
    return o;
  endfunction

  function automatic logic [5:0] msb_index(logic [32:0] m);
    logic [5:0] p;
    p = '0;
    for (int b = 0; b < 33; b++) begin
      if (m[b]) p = 6'(b);
    end
    return p;
  endfunction

endpackage

@@ rtl/capstan_cable_length.sv @@
// ----------------------------------------------------------------------------
// capstan_cable_length
// Cable position of a capstan winch for one toolhead XY point per item.
// ----------------------------------------------------------------------------
// Fully pipelined: one item per cycle while out_stall does not hold the output.
// The depth is set by the 41-stage bit-per-stage square root of the free
// length, which carries the direction CORDIC in its first stages, followed
// by the tangent CORDIC (one stage per iteration) and a split 57x64
// multiply for the wound part. The whole pipeline advances together;
// in_stall follows out_stall while the output register holds an item.
module capstan_cable_length #(
  parameter int CORDIC_ITERATIONS = ccl_pkg::CORDIC_ITERATIONS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] out_cable_length,
  output logic               out_inside_radius
);

  localparam int SQ_N = ccl_pkg::SQRT_BITS;

  logic [31:0] cen_x_r, cen_y_r, angle_origin_r;
  logic [23:0] radius_r;
  logic        adv;
  logic        out_valid_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cen_x_r        <= '0;
      cen_y_r        <= '0;
      radius_r       <= '0;
      angle_origin_r <= '0;
    end else if (cfg_we) begin
      case (ccl_pkg::cfg_reg_t'(cfg_index))
        ccl_pkg::REG_ANCHOR_X:     cen_x_r        <= cfg_data;
        ccl_pkg::REG_ANCHOR_Y:     cen_y_r        <= cfg_data;
        ccl_pkg::REG_RADIUS:       radius_r       <= cfg_data[23:0];
        ccl_pkg::REG_ANGLE_ORIGIN: angle_origin_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // offset from anchor
  logic        p0_v_r;
  logic [32:0] p0_ex_r, p0_ey_r;

  always_ff @(posedge clk) begin
    if (!rst_n) p0_v_r <= 1'b0;
    else if (adv) p0_v_r <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      p0_ex_r <= {in_pos_x[31], in_pos_x} - {cen_x_r[31], cen_x_r};
      p0_ey_r <= {in_pos_y[31], in_pos_y} - {cen_y_r[31], cen_y_r};
    end
  end

  // squares, pre-rotation
  logic        p1_v_r;
  logic [65:0] p1_sqx_r, p1_sqy_r;
  logic [47:0] p1_r2_r;
  logic [33:0] p1_dx_r, p1_dy_r;
  logic [31:0] p1_z_r;
  logic [32:0] p1_m_r;
  logic        p1_zero_r;
  logic [32:0] mx, my;
  logic [33:0] ex34, ey34;

  always_comb begin
    mx   = p0_ex_r[32] ? (~p0_ex_r + 33'd1) : p0_ex_r;
    my   = p0_ey_r[32] ? (~p0_ey_r + 33'd1) : p0_ey_r;
    ex34 = {p0_ex_r[32], p0_ex_r};
    ey34 = {p0_ey_r[32], p0_ey_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) p1_v_r <= 1'b0;
    else if (adv) p1_v_r <= p0_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_sqx_r  <= 66'(mx) * 66'(mx);
      p1_sqy_r  <= 66'(my) * 66'(my);
      p1_r2_r   <= 48'(radius_r) * 48'(radius_r);
      p1_dx_r   <= p0_ex_r[32] ? (~ex34 + 34'd1) : ex34;
      p1_dy_r   <= p0_ex_r[32] ? (~ey34 + 34'd1) : ey34;
      p1_z_r    <= p0_ex_r[32] ? 32'h8000_0000 : 32'h0;
      p1_m_r    <= (mx > my) ? mx : my;
      p1_zero_r <= (p0_ex_r == '0) && (p0_ey_r == '0);
    end
  end

  // radicand, normalize shift
  logic        p2_v_r;
  logic [66:0] p2_s_r;
  logic        p2_inside_r;
  logic [33:0] p2_dx_r, p2_dy_r;
  logic [31:0] p2_z_r;
  logic [5:0]  p2_k_r;
  logic        p2_zero_r;
  logic [66:0] d2;
  logic        inside_nxt;

  always_comb begin
    d2         = {1'b0, p1_sqx_r} + {1'b0, p1_sqy_r};
    inside_nxt = d2 < {19'd0, p1_r2_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) p2_v_r <= 1'b0;
    else if (adv) p2_v_r <= p1_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      p2_s_r      <= inside_nxt ? '0 : d2 - {19'd0, p1_r2_r};
      p2_inside_r <= inside_nxt;
      p2_dx_r     <= p1_dx_r;
      p2_dy_r     <= p1_dy_r;
      p2_z_r      <= p1_z_r;
      p2_k_r      <= 6'(ccl_pkg::NORM_TOP) - ccl_pkg::msb_index(p1_m_r);
      p2_zero_r   <= p1_zero_r;
    end
  end

  // shift into CORDIC range
  logic          p3_v_r;
  ccl_pkg::sq_t  p3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) p3_v_r <= 1'b0;
    else if (adv) p3_v_r <= p2_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      p3_r.rem      <= p2_s_r;
      p3_r.res      <= '0;
      p3_r.dv.x     <= {{30{p2_dx_r[33]}}, p2_dx_r} << p2_k_r;
      p3_r.dv.y     <= {{30{p2_dy_r[33]}}, p2_dy_r} << p2_k_r;
      p3_r.dv.z     <= p2_z_r;
      p3_r.dzero    <= p2_zero_r;
      p3_r.interior <= p2_inside_r;
    end
  end

  // square root, one result bit per stage; direction CORDIC rides along
  ccl_pkg::sq_t sq_r   [SQ_N];
  logic         sq_v_r [SQ_N];

  for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
    localparam int SB = SQ_N - 1 - j;
    ccl_pkg::sq_t  src;
    ccl_pkg::sq_t  stg_nxt;
    ccl_pkg::vec_t dv_nxt;
    logic          src_v;
    logic [83:0]   trial;

    if (j == 0) begin : g_first
      assign src   = p3_r;
      assign src_v = p3_v_r;
    end else begin : g_next
      assign src   = sq_r[j-1];
      assign src_v = sq_v_r[j-1];
    end

    if (j < CORDIC_ITERATIONS) begin : g_rot
      assign dv_nxt = ccl_pkg::cordic_step(src.dv, j);
    end else begin : g_hold
      assign dv_nxt = src.dv;
    end

    always_comb begin
      stg_nxt    = src;
      stg_nxt.dv = dv_nxt;
      trial      = ({43'd0, src.res} << (SB + 1)) + (84'd1 << (2 * SB));
      if ({17'd0, src.rem} >= trial) begin
        stg_nxt.rem = src.rem - trial[66:0];
        stg_nxt.res = src.res | (41'd1 << SB);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) sq_v_r[j] <= 1'b0;
      else if (adv) sq_v_r[j] <= src_v;
    end
    always_ff @(posedge clk) begin
      if (adv) sq_r[j] <= stg_nxt;
    end
  end

  // wrap angle, tangent magnitude
  logic        t0_v_r;
  logic [31:0] t0_diff_r;
  logic [32:0] t0_ucl_r;
  logic        t0_inside_r;
  logic [32:0] t0_m_r;
  logic        t0_tzero_r;
  logic [32:0] ucl;
  logic [31:0] dir_z;

  always_comb begin
    ucl   = sq_r[SQ_N-1].res[32:0];
    dir_z = sq_r[SQ_N-1].dzero ? '0 : sq_r[SQ_N-1].dv.z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) t0_v_r <= 1'b0;
    else if (adv) t0_v_r <= sq_v_r[SQ_N-1];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      t0_diff_r   <= dir_z - angle_origin_r;
      t0_ucl_r    <= ucl;
      t0_inside_r <= sq_r[SQ_N-1].interior;
      t0_m_r      <= (ucl > {9'd0, radius_r}) ? ucl : {9'd0, radius_r};
      t0_tzero_r  <= (ucl == '0) && (radius_r == '0);
    end
  end

  logic        t1_v_r;
  logic [31:0] t1_diff_r;
  logic [32:0] t1_ucl_r;
  logic        t1_inside_r;
  logic [5:0]  t1_k_r;
  logic        t1_tzero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) t1_v_r <= 1'b0;
    else if (adv) t1_v_r <= t0_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      t1_diff_r   <= t0_diff_r;
      t1_ucl_r    <= t0_ucl_r;
      t1_inside_r <= t0_inside_r;
      t1_k_r      <= 6'(ccl_pkg::NORM_TOP) - ccl_pkg::msb_index(t0_m_r);
      t1_tzero_r  <= t0_tzero_r;
    end
  end

  logic         t2_v_r;
  ccl_pkg::tg_t t2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) t2_v_r <= 1'b0;
    else if (adv) t2_v_r <= t1_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      t2_r.v.x      <= {31'd0, t1_ucl_r} << t1_k_r;
      t2_r.v.y      <= {40'd0, radius_r} << t1_k_r;
      t2_r.v.z      <= '0;
      t2_r.diff     <= t1_diff_r;
      t2_r.ucl      <= t1_ucl_r;
      t2_r.interior <= t1_inside_r;
      t2_r.tzero    <= t1_tzero_r;
    end
  end

  // tangent CORDIC, one iteration per stage
  ccl_pkg::tg_t cd_r   [CORDIC_ITERATIONS];
  logic         cd_v_r [CORDIC_ITERATIONS];

  for (genvar j = 0; j < CORDIC_ITERATIONS; j++) begin : g_tan
    ccl_pkg::tg_t src;
    ccl_pkg::tg_t stg_nxt;
    logic         src_v;

    if (j == 0) begin : g_first
      assign src   = t2_r;
      assign src_v = t2_v_r;
    end else begin : g_next
      assign src   = cd_r[j-1];
      assign src_v = cd_v_r[j-1];
    end

    always_comb begin
      stg_nxt   = src;
      stg_nxt.v = ccl_pkg::cordic_step(src.v, j);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) cd_v_r[j] <= 1'b0;
      else if (adv) cd_v_r[j] <= src_v;
    end
    always_ff @(posedge clk) begin
      if (adv) cd_r[j] <= stg_nxt;
    end
  end

  // angle sum
  logic        a0_v_r;
  logic        a0_neg_r;
  logic [32:0] a0_mag_r;
  logic [32:0] a0_ucl_r;
  logic        a0_inside_r;
  logic [31:0] tang;
  logic [32:0] a_sum;

  always_comb begin
    tang  = cd_r[CORDIC_ITERATIONS-1].tzero ? '0 : cd_r[CORDIC_ITERATIONS-1].v.z;
    a_sum = {cd_r[CORDIC_ITERATIONS-1].diff[31], cd_r[CORDIC_ITERATIONS-1].diff}
          + {tang[31], tang};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) a0_v_r <= 1'b0;
    else if (adv) a0_v_r <= cd_v_r[CORDIC_ITERATIONS-1];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      a0_neg_r    <= a_sum[32];
      a0_mag_r    <= a_sum[32] ? (~a_sum + 33'd1) : a_sum;
      a0_ucl_r    <= cd_r[CORDIC_ITERATIONS-1].ucl;
      a0_inside_r <= cd_r[CORDIC_ITERATIONS-1].interior;
    end
  end

  // r times angle
  logic        a1_v_r;
  logic        a1_neg_r;
  logic [56:0] a1_p_r;
  logic [32:0] a1_ucl_r;
  logic        a1_inside_r;

  always_ff @(posedge clk) begin
    if (!rst_n) a1_v_r <= 1'b0;
    else if (adv) a1_v_r <= a0_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      a1_p_r      <= 57'(radius_r) * 57'(a0_mag_r);
      a1_neg_r    <= a0_neg_r;
      a1_ucl_r    <= a0_ucl_r;
      a1_inside_r <= a0_inside_r;
    end
  end

  // times pi, partial products
  logic        m1_v_r;
  logic [59:0] m1_ll_r, m1_lh_r;
  logic [60:0] m1_hl_r, m1_hh_r;
  logic        m1_neg_r;
  logic [32:0] m1_ucl_r;
  logic        m1_inside_r;

  always_ff @(posedge clk) begin
    if (!rst_n) m1_v_r <= 1'b0;
    else if (adv) m1_v_r <= a1_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m1_ll_r     <= 60'(a1_p_r[27:0])  * 60'(ccl_pkg::PI_Q61[31:0]);
      m1_lh_r     <= 60'(a1_p_r[27:0])  * 60'(ccl_pkg::PI_Q61[63:32]);
      m1_hl_r     <= 61'(a1_p_r[56:28]) * 61'(ccl_pkg::PI_Q61[31:0]);
      m1_hh_r     <= 61'(a1_p_r[56:28]) * 61'(ccl_pkg::PI_Q61[63:32]);
      m1_neg_r    <= a1_neg_r;
      m1_ucl_r    <= a1_ucl_r;
      m1_inside_r <= a1_inside_r;
    end
  end

  logic         m2_v_r;
  logic [120:0] m2_sa_r, m2_sb_r;
  logic         m2_neg_r;
  logic [32:0]  m2_ucl_r;
  logic         m2_inside_r;

  always_ff @(posedge clk) begin
    if (!rst_n) m2_v_r <= 1'b0;
    else if (adv) m2_v_r <= m1_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m2_sa_r     <= 121'(m1_ll_r) + (121'(m1_lh_r) << 32);
      m2_sb_r     <= (121'(m1_hl_r) << 28) + (121'(m1_hh_r) << 60);
      m2_neg_r    <= m1_neg_r;
      m2_ucl_r    <= m1_ucl_r;
      m2_inside_r <= m1_inside_r;
    end
  end

  logic         m3_v_r;
  logic [120:0] m3_prod_r;
  logic         m3_neg_r;
  logic [32:0]  m3_ucl_r;
  logic         m3_inside_r;

  always_ff @(posedge clk) begin
    if (!rst_n) m3_v_r <= 1'b0;
    else if (adv) m3_v_r <= m2_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m3_prod_r   <= m2_sa_r + m2_sb_r;
      m3_neg_r    <= m2_neg_r;
      m3_ucl_r    <= m2_ucl_r;
      m3_inside_r <= m2_inside_r;
    end
  end

  // round half away from zero
  logic        m4_v_r;
  logic [28:0] m4_q_r;
  logic        m4_neg_r;
  logic [32:0] m4_ucl_r;
  logic        m4_inside_r;
  logic [56:0] q_sum;

  always_comb begin
    q_sum = {1'b0, m3_prod_r[119:64]} + 57'(1 << 27);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) m4_v_r <= 1'b0;
    else if (adv) m4_v_r <= m3_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m4_q_r      <= q_sum[56:28];
      m4_neg_r    <= m3_neg_r;
      m4_ucl_r    <= m3_ucl_r;
      m4_inside_r <= m3_inside_r;
    end
  end

  // output register
  logic [47:0] cable_nxt;
  logic [47:0] q48;
  logic [47:0] cable_r;
  logic        inside_r;

  always_comb begin
    q48       = {19'd0, m4_q_r};
    cable_nxt = {15'd0, m4_ucl_r} + (m4_neg_r ? (~q48 + 48'd1) : q48);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= m4_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      cable_r  <= cable_nxt;
      inside_r <= m4_inside_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cable_length  = $signed(cable_r);
  assign out_inside_radius = inside_r;

endmodule
